### sv/rspd_pkg.sv
// Shared types and constants for the paletted run-length sprite decoder.
// Used by every module of the block; depends on nothing.
package rspd_pkg;

  // palette store geometry
  localparam int unsigned PALETTE_DEPTH = 256;
  localparam int unsigned PAL_AW        = $clog2(PALETTE_DEPTH);

  // request commands
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_BYTE  = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;

  // configuration register indexes
  localparam logic [7:0] REG_COMPRESSED = 8'd0;
  localparam logic [7:0] REG_COL_MAJOR  = 8'd1;
  localparam logic [7:0] REG_LINE_LEN   = 8'd2;
  localparam logic [7:0] REG_LINE_CNT   = 8'd3;

  // result kinds and fixed alpha
  localparam logic       KIND_PIXEL   = 1'b0;
  localparam logic       KIND_END     = 1'b1;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  // results produced by one request, handed from the parser to the output stage
  typedef struct packed {
    logic        pix;
    logic        fin;
    logic [15:0] x;
    logic [15:0] y;
    logic        dropped;
  } rec_t;

endpackage

### sv/rspd_palette.sv
// Palette color memory with per-entry valid flags and a registered read port.
// Depends on rspd_pkg for the palette depth.
module rspd_palette import rspd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        wr_en_i,
  input  logic [7:0]  wr_idx_i,
  input  logic        wr_present_i,
  input  logic [23:0] wr_color_i,
  input  logic        rd_en_i,
  input  logic [7:0]  rd_idx_i,
  output logic [23:0] rd_color_o,
  output logic        rd_valid_o
);

  logic [23:0]              mem [PALETTE_DEPTH];
  logic [PALETTE_DEPTH-1:0] valid_q;
  logic [23:0]              rd_color_q;
  logic                     rd_valid_q;
  logic                     wr_ok;
  logic                     rd_ok;

  // indexes past the store are ignored on write and read as absent
  assign wr_ok = {1'b0, wr_idx_i} < 9'(PALETTE_DEPTH);
  assign rd_ok = {1'b0, rd_idx_i} < 9'(PALETTE_DEPTH);

  // color memory, no reset
  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_ok) begin
      mem[wr_idx_i[PAL_AW-1:0]] <= wr_color_i;
    end
    if (rd_en_i) begin
      rd_color_q <= mem[rd_idx_i[PAL_AW-1:0]];
    end
  end

  // valid flags, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i && wr_ok) begin
        valid_q[wr_idx_i[PAL_AW-1:0]] <= wr_present_i;
      end
      if (rd_en_i) begin
        rd_valid_q <= rd_ok && valid_q[rd_idx_i[PAL_AW-1:0]];
      end
    end
  end

  assign rd_color_o = rd_color_q;
  assign rd_valid_o = rd_valid_q;

  // the store is never written and read in the same cycle
  a_no_rw_same_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_en_i && rd_en_i))
    else $error("palette written and read in one cycle");

endmodule

### sv/rspd_parse.sv
// Stream parser: configuration registers, command parsing, line and position
// counters. Produces the pixel and end records of each request. Uses rspd_pkg.
module rspd_parse import rspd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_fire_i,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  stream_byte_i,
  input  logic        cfg_valid_i,
  input  logic [7:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output rec_t        rec_o
);

  // parse phase codes
  localparam logic [1:0] PH_HIGH = 2'd0;
  localparam logic [1:0] PH_LOW  = 2'd1;
  localparam logic [1:0] PH_LIT  = 2'd2;

  logic        compressed_q, col_major_q;
  logic [15:0] line_len_q, line_cnt_q;

  logic [1:0]  phase_q, phase_d;
  logic [7:0]  cmd_hi_q, cmd_hi_d;
  logic [14:0] lit_left_q, lit_left_d;
  logic [15:0] line_idx_q, line_idx_d;
  logic [15:0] line_pos_q, line_pos_d;
  logic        done_q, done_d;

  logic [15:0] word;
  logic [16:0] step;
  logic [16:0] sum;
  logic [15:0] pos_adv;
  logic        last_line;
  rec_t        rec;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      compressed_q <= 1'b0;
      col_major_q  <= 1'b0;
      line_len_q   <= 16'd1;
      line_cnt_q   <= 16'd1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_COMPRESSED: compressed_q <= cfg_data_i[0];
        REG_COL_MAJOR:  col_major_q  <= cfg_data_i[0];
        REG_LINE_LEN:   line_len_q   <= cfg_data_i;
        REG_LINE_CNT:   line_cnt_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // shared position adder: one step for a pixel, the run length for a skip
  assign word      = {cmd_hi_q, stream_byte_i};
  assign step      = (!compressed_q || phase_q == PH_LIT) ? 17'd1
                                                          : 17'h10000 - {1'b0, word};
  assign sum       = {1'b0, line_pos_q} + step;
  assign pos_adv   = sum[16] ? 16'hFFFF : sum[15:0];
  assign last_line = ({1'b0, line_idx_q} + 17'd1) >= {1'b0, line_cnt_q};

  // next state and records
  always_comb begin
    phase_d    = phase_q;
    cmd_hi_d   = cmd_hi_q;
    lit_left_d = lit_left_q;
    line_idx_d = line_idx_q;
    line_pos_d = line_pos_q;
    done_d     = done_q;
    rec         = '0;
    rec.x       = col_major_q ? line_idx_q : line_pos_q;
    rec.y       = col_major_q ? line_pos_q : line_idx_q;
    rec.dropped = (line_pos_q >= line_len_q) || (line_idx_q >= line_cnt_q);
    if (in_fire_i) begin
      case (cmd_i)
        CMD_START: begin
          phase_d    = PH_HIGH;
          cmd_hi_d   = '0;
          lit_left_d = '0;
          line_idx_d = '0;
          line_pos_d = '0;
          done_d     = 1'b0;
        end
        CMD_BYTE: begin
          if (!done_q) begin
            if (!compressed_q) begin
              // raw byte: one pixel, line ends at the line length
              rec.pix = 1'b1;
              if (pos_adv >= line_len_q) begin
                line_pos_d = '0;
                if (last_line) begin
                  done_d  = 1'b1;
                  rec.fin = 1'b1;
                end else begin
                  line_idx_d = line_idx_q + 16'd1;
                end
              end else begin
                line_pos_d = pos_adv;
              end
            end else begin
              unique case (phase_q)
                PH_LIT: begin
                  rec.pix    = 1'b1;
                  line_pos_d = pos_adv;
                  lit_left_d = lit_left_q - 15'd1;
                  if (lit_left_q == 15'd1) begin
                    phase_d = PH_HIGH;
                  end
                end
                PH_LOW: begin
                  phase_d = PH_HIGH;
                  if (word == 16'd0) begin
                    // end of line command
                    line_pos_d = '0;
                    if (last_line) begin
                      done_d  = 1'b1;
                      rec.fin = 1'b1;
                    end else begin
                      line_idx_d = line_idx_q + 16'd1;
                    end
                  end else if (word[15]) begin
                    line_pos_d = pos_adv;
                  end else begin
                    lit_left_d = word[14:0];
                    phase_d    = PH_LIT;
                  end
                end
                default: begin
                  cmd_hi_d = stream_byte_i;
                  phase_d  = PH_LOW;
                end
              endcase
            end
          end
        end
        default: ;
      endcase
    end
  end

  // parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HIGH;
      cmd_hi_q   <= '0;
      lit_left_q <= '0;
      line_idx_q <= '0;
      line_pos_q <= '0;
      done_q     <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      cmd_hi_q   <= cmd_hi_d;
      lit_left_q <= lit_left_d;
      line_idx_q <= line_idx_d;
      line_pos_q <= line_pos_d;
      done_q     <= done_d;
    end
  end

  assign rec_o = rec;

  // a literal run in progress always has bytes left
  a_lit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_LIT) |-> (lit_left_q != 15'd0))
    else $error("literal phase with empty count");

  // a finished image stays finished until a restart
  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> (done_q || $past(in_fire_i && cmd_i == CMD_START)))
    else $error("image done cleared without restart");

  // an end record always marks the image finished
  a_fin_sets_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec.fin |=> done_q)
    else $error("end record without image done");

endmodule

### sv/rspd_out.sv
// Output register holding up to one pixel record and one end record, with
// rgba built from the registered palette read. Uses rspd_pkg.
module rspd_out import rspd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        take_i,
  input  rec_t        rec_i,
  input  logic [23:0] rd_color_i,
  input  logic        rd_valid_i,
  output logic        can_take_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [15:0] pix_x_o,
  output logic [15:0] pix_y_o,
  output logic [31:0] rgba_o,
  output logic        dropped_o
);

  logic        pix_q, pix_d;
  logic        fin_q, fin_d;
  logic [15:0] x_q, y_q;
  logic        drop_q;
  logic        out_fire;
  logic        load;

  assign out_fire   = out_valid_o && out_ready_i;
  assign load       = take_i && (rec_i.pix || rec_i.fin);
  // ready to take a request unless something is left after this cycle's handshake
  assign can_take_o = !((pix_q && fin_q) || ((pix_q || fin_q) && !out_ready_i));

  // pending flags: pixel goes first, then the end record
  always_comb begin
    pix_d = pix_q;
    fin_d = fin_q;
    if (out_fire) begin
      if (pix_q) begin
        pix_d = 1'b0;
      end else begin
        fin_d = 1'b0;
      end
    end
    if (load) begin
      pix_d = rec_i.pix;
      fin_d = rec_i.fin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q <= 1'b0;
      fin_q <= 1'b0;
    end else begin
      pix_q <= pix_d;
      fin_q <= fin_d;
    end
  end

  // pixel payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      x_q    <= rec_i.x;
      y_q    <= rec_i.y;
      drop_q <= rec_i.dropped;
    end
  end

  // result fields
  assign out_valid_o = pix_q || fin_q;
  assign kind_o      = pix_q ? KIND_PIXEL : KIND_END;
  assign pix_x_o     = pix_q ? x_q : 16'd0;
  assign pix_y_o     = pix_q ? y_q : 16'd0;
  assign rgba_o      = (pix_q && rd_valid_i) ? {rd_color_i, ALPHA_OPAQUE} : 32'd0;
  assign dropped_o   = pix_q && drop_q;

  // new results only land in an empty or emptying register
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (!(pix_q && fin_q) && (!(pix_q || fin_q) || out_ready_i)))
    else $error("output register overwritten");

  // a refused request means a result is still waiting
  a_busy_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !can_take_o |-> out_valid_o)
    else $error("input stalled with empty output");

endmodule

### sv/rle_sprite_palette_decoder.sv
// Channel | handshake              | payload
// in      | in_valid_i/in_ready_o   | cmd, stream_byte, pal_index/present/red/green/blue
// out     | out_valid_o/out_ready_i | kind, pix_x, pix_y, rgba, dropped
// cfg     | cfg_valid_i/cfg_ready_o | cfg_index_i (0..3), cfg_data_i (16 bits)
//
// One request per cycle while in_ready_o is high: parse state updates and the
// palette read happen at the accepting edge; results appear in the output register the cycle after.
// A raw byte that closes the image gives two results, holding off input while both are pending.
// Reset clears parse state, configuration and all palette valid flags at once.
// in_ready_o drops only while the output register still holds an untaken result.
// Top level: parser, palette store and output register. Uses rspd_pkg.
module rle_sprite_palette_decoder import rspd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  stream_byte_i,
  input  logic [7:0]  pal_index_i,
  input  logic        pal_present_i,
  input  logic [7:0]  pal_red_i,
  input  logic [7:0]  pal_green_i,
  input  logic [7:0]  pal_blue_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [15:0] pix_x_o,
  output logic [15:0] pix_y_o,
  output logic [31:0] rgba_o,
  output logic        dropped_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic        in_fire;
  rec_t        rec;
  logic [23:0] rd_color;
  logic        rd_valid;

  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // command parsing and counters
  rspd_parse u_parse (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_fire_i     (in_fire),
    .cmd_i         (cmd_i),
    .stream_byte_i (stream_byte_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .rec_o         (rec)
  );

  // palette store: loads write, pixels read
  rspd_palette u_palette (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_en_i      (in_fire && cmd_i == CMD_LOAD),
    .wr_idx_i     (pal_index_i),
    .wr_present_i (pal_present_i),
    .wr_color_i   ({pal_red_i, pal_green_i, pal_blue_i}),
    .rd_en_i      (in_fire && rec.pix),
    .rd_idx_i     (stream_byte_i),
    .rd_color_o   (rd_color),
    .rd_valid_o   (rd_valid)
  );

  // result register
  rspd_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (in_fire),
    .rec_i       (rec),
    .rd_color_i  (rd_color),
    .rd_valid_i  (rd_valid),
    .can_take_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .pix_x_o     (pix_x_o),
    .pix_y_o     (pix_y_o),
    .rgba_o      (rgba_o),
    .dropped_o   (dropped_o)
  );

endmodule

### tb/rspd_record_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the paletted run-length sprite decoder: watches the three channels,
// predicts each request's pixel and end records, and checks the results in order.
// Depends on rspd_pkg for command, register and kind codes.
module rspd_record_checker import rspd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  stream_byte_i,
  input  logic [7:0]  pal_index_i,
  input  logic        pal_present_i,
  input  logic [7:0]  pal_red_i,
  input  logic [7:0]  pal_green_i,
  input  logic [7:0]  pal_blue_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        kind_i,
  input  logic [15:0] pix_x_i,
  input  logic [15:0] pix_y_i,
  input  logic [31:0] rgba_i,
  input  logic        dropped_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [7:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int          errors_o,
  output int          pending_o
);

  typedef enum logic [1:0] {AWAIT_HIGH, AWAIT_LOW, LITERAL_RUN} parse_e;

  typedef struct packed {
    logic        kind;
    logic [15:0] x;
    logic [15:0] y;
    logic [31:0] rgba;
    logic        dropped;
  } sprite_rec_t;

  // palette copy
  logic [23:0] pal_rgb [PALETTE_DEPTH];
  bit          pal_ok  [PALETTE_DEPTH];

  // stream parser copy
  parse_e      parse_st;
  logic [7:0]  cmd_hi;
  logic [14:0] lit_left;
  logic [15:0] line_idx;
  logic [15:0] line_pos;
  bit          img_done;

  // format registers
  bit          rle_mode;
  bit          col_major;
  logic [15:0] line_len;
  logic [15:0] line_cnt;

  sprite_rec_t due_records [$];
  int          fail_count;

  function automatic void restart_image();
    parse_st = AWAIT_HIGH;
    cmd_hi   = '0;
    lit_left = '0;
    line_idx = '0;
    line_pos = '0;
    img_done = 1'b0;
  endfunction

  function automatic sprite_rec_t end_record();
    sprite_rec_t r;
    r      = '0;
    r.kind = KIND_END;
    return r;
  endfunction

  // write record for the current position, colored through the palette
  function automatic sprite_rec_t pixel_record(logic [7:0] idx);
    sprite_rec_t r;
    r.kind    = KIND_PIXEL;
    r.x       = col_major ? line_idx : line_pos;
    r.y       = col_major ? line_pos : line_idx;
    r.rgba    = (int'(idx) < PALETTE_DEPTH && pal_ok[idx]) ? {pal_rgb[idx], ALPHA_OPAQUE} : '0;
    r.dropped = (line_pos >= line_len) || (line_idx >= line_cnt);
    return r;
  endfunction

  // position saturates at the top of its range
  function automatic void advance_pos(int unsigned n);
    int unsigned p;
    p        = int'(line_pos) + n;
    line_pos = (p > 32'hFFFF) ? 16'hFFFF : p[15:0];
  endfunction

  // returns 1 when the closed line was the last of the image
  function automatic bit close_line();
    line_pos = '0;
    if (int'(line_idx) + 1 >= int'(line_cnt)) begin
      img_done = 1'b1;
      return 1'b1;
    end
    line_idx = line_idx + 16'd1;
    return 1'b0;
  endfunction

  function automatic void decode_byte(logic [7:0] b);
    logic [15:0] word;
    if (!rle_mode) begin
      due_records.push_back(pixel_record(b));
      advance_pos(1);
      if (line_pos >= line_len) begin
        if (close_line()) due_records.push_back(end_record());
      end
      return;
    end
    case (parse_st)
      LITERAL_RUN: begin
        due_records.push_back(pixel_record(b));
        advance_pos(1);
        lit_left = lit_left - 15'd1;
        if (lit_left == '0) parse_st = AWAIT_HIGH;
      end
      AWAIT_LOW: begin
        word     = {cmd_hi, b};
        parse_st = AWAIT_HIGH;
        if (word == '0) begin
          if (close_line()) due_records.push_back(end_record());
        end else if (word[15]) begin
          advance_pos(32'h10000 - word);
        end else begin
          lit_left = word[14:0];
          parse_st = LITERAL_RUN;
        end
      end
      default: begin
        cmd_hi   = b;
        parse_st = AWAIT_LOW;
      end
    endcase
  endfunction

  function automatic void decode_request();
    case (cmd_i)
      CMD_LOAD: begin
        if (int'(pal_index_i) < PALETTE_DEPTH) begin
          pal_ok[pal_index_i]  = pal_present_i;
          pal_rgb[pal_index_i] = {pal_red_i, pal_green_i, pal_blue_i};
        end
      end
      CMD_START: restart_image();
      CMD_BYTE: begin
        if (!img_done) decode_byte(stream_byte_i);
      end
      default: ;
    endcase
  endfunction

  function automatic void apply_register(logic [7:0] idx, logic [15:0] data);
    case (idx)
      REG_COMPRESSED: rle_mode  = data[0];
      REG_COL_MAJOR:  col_major = data[0];
      REG_LINE_LEN:   line_len  = data;
      REG_LINE_CNT:   line_cnt  = data;
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void check_record();
    sprite_rec_t want;
    if (due_records.size() == 0) begin
      $error("unexpected result: kind %0d x %0d y %0d rgba %0h dropped %0d",
             kind_i, pix_x_i, pix_y_i, rgba_i, dropped_i);
      fail_count++;
      return;
    end
    want = due_records.pop_front();
    check_field("kind", 32'(want.kind), 32'(kind_i));
    check_field("pix_x", 32'(want.x), 32'(pix_x_i));
    check_field("pix_y", 32'(want.y), 32'(pix_y_i));
    check_field("rgba", want.rgba, rgba_i);
    check_field("dropped", 32'(want.dropped), 32'(dropped_i));
  endfunction

  // sample all channels at the clock edge, requests before results
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PALETTE_DEPTH; i++) begin
        pal_rgb[i] = '0;
        pal_ok[i]  = 1'b0;
      end
      rle_mode  = 1'b0;
      col_major = 1'b0;
      line_len  = 16'd1;
      line_cnt  = 16'd1;
      restart_image();
      due_records.delete();
      fail_count = 0;
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) apply_register(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_i) decode_request();
      if (out_valid_i && out_ready_i) check_record();
      errors_o  <= fail_count;
      pending_o <= due_records.size();
    end
  end

endmodule

### tb/rle_sprite_palette_decoder_tb.sv
`timescale 1ns / 1ps
// Top of the sprite decoder testbench: clock, reset, request and register stimulus,
// result-side backpressure and the verdict. Depends on rspd_pkg and rspd_record_checker.
module rle_sprite_palette_decoder_tb import rspd_pkg::*;;

  localparam logic [1:0]  CMD_SPARE    = 2'd3;
  localparam int unsigned ITEM_TARGET  = 1450;
  localparam int unsigned RX_HOLD      = 300;
  localparam int unsigned RUN_LIMIT_NS = 2000000;

  typedef struct {
    logic [1:0] cmd;
    logic [7:0] sbyte;
    logic [7:0] pidx;
    logic       pres;
    logic [7:0] red;
    logic [7:0] grn;
    logic [7:0] blu;
  } req_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic [1:0]  cmd_i         = CMD_LOAD;
  logic [7:0]  stream_byte_i = '0;
  logic [7:0]  pal_index_i   = '0;
  logic        pal_present_i = 1'b0;
  logic [7:0]  pal_red_i     = '0;
  logic [7:0]  pal_green_i   = '0;
  logic [7:0]  pal_blue_i    = '0;
  logic        out_ready_i   = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic [7:0]  cfg_index_i   = '0;
  logic [15:0] cfg_data_i    = '0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic        kind_o;
  logic [15:0] pix_x_o;
  logic [15:0] pix_y_o;
  logic [31:0] rgba_o;
  logic        dropped_o;
  logic        cfg_ready_o;

  int          check_errors;
  int          check_pending;

  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  int          hold_asked   = 0;
  int          hold_done    = 0;
  int unsigned items_sent   = 0;

  // format currently programmed, used to size the generated images
  bit          cur_comp;
  int unsigned cur_len;
  int unsigned cur_cnt;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  rle_sprite_palette_decoder u_dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o,
    .cmd_i, .stream_byte_i, .pal_index_i, .pal_present_i,
    .pal_red_i, .pal_green_i, .pal_blue_i,
    .out_valid_o, .out_ready_i,
    .kind_o, .pix_x_o, .pix_y_o, .rgba_o, .dropped_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  rspd_record_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o),
    .cmd_i, .stream_byte_i, .pal_index_i, .pal_present_i,
    .pal_red_i, .pal_green_i, .pal_blue_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .kind_i(kind_o), .pix_x_i(pix_x_o), .pix_y_i(pix_y_o),
    .rgba_i(rgba_o), .dropped_i(dropped_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .errors_o(check_errors), .pending_o(check_pending)
  );

  // result side: random stalls, or a long hold-off counted here when one is asked for
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_done != hold_asked) begin
        out_ready_i <= 1'b0;
        repeat (RX_HOLD) @(posedge clk_i);
        hold_done++;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // request with every field random, so ignored fields toggle too
  function automatic req_t random_req(logic [1:0] c);
    req_t q;
    q.cmd   = c;
    q.sbyte = 8'($urandom);
    q.pidx  = 8'($urandom);
    q.pres  = 1'($urandom);
    q.red   = 8'($urandom);
    q.grn   = 8'($urandom);
    q.blu   = 8'($urandom);
    return q;
  endfunction

  // returns at the edge that accepts the request, valid still high
  task automatic send_request(req_t q);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    cmd_i         <= q.cmd;
    stream_byte_i <= q.sbyte;
    pal_index_i   <= q.pidx;
    pal_present_i <= q.pres;
    pal_red_i     <= q.red;
    pal_green_i   <= q.grn;
    pal_blue_i    <= q.blu;
    do @(posedge clk_i); while (!in_ready_o);
    if (q.cmd != CMD_SPARE) items_sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    req_t q;
    q       = random_req(CMD_BYTE);
    q.sbyte = b;
    send_request(q);
  endtask

  // big-endian run command
  task automatic send_word(logic [15:0] w);
    send_byte(w[15:8]);
    send_byte(w[7:0]);
  endtask

  task automatic send_load(logic [7:0] idx, logic present);
    req_t q;
    q      = random_req(CMD_LOAD);
    q.pidx = idx;
    q.pres = present;
    send_request(q);
  endtask

  task automatic send_start();
    send_request(random_req(CMD_START));
  endtask

  // sender stops until every predicted result has come out
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (check_pending != 0);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // reprogram the format once the block has gone quiet
  task automatic set_format(bit comp, bit colmaj, logic [15:0] len, logic [15:0] cnt);
    drain_results();
    repeat (4) @(posedge clk_i);
    if ($urandom_range(3) == 0) write_reg(8'($urandom_range(4, 255)), 16'($urandom));
    write_reg(REG_COMPRESSED, {15'($urandom), comp});
    write_reg(REG_COL_MAJOR, {15'($urandom), colmaj});
    write_reg(REG_LINE_LEN, len);
    write_reg(REG_LINE_CNT, cnt);
    cfg_valid_i <= 1'b0;
    cur_comp = comp;
    cur_len  = 32'(len);
    cur_cnt  = 32'(cnt);
  endtask

  // raw image: one byte per pixel, sometimes cut short or followed by a stray byte
  task automatic raw_image(bit fresh);
    int unsigned total;
    if (fresh) send_start();
    total = (cur_len == 0 ? 1 : cur_len) * (cur_cnt == 0 ? 1 : cur_cnt);
    if (total > 40) total = $urandom_range(8, 40);
    if ($urandom_range(9) == 0) total = $urandom_range(1, total);
    repeat (total) send_byte(8'($urandom));
    if ($urandom_range(3) == 0) send_byte(8'($urandom));
  endtask

  // run-command image: skips and literal runs per line, closed by a zero command
  task automatic rle_image(bit fresh);
    int unsigned lines;
    int unsigned span;
    int unsigned n;
    if (fresh) send_start();
    lines = (cur_cnt == 0 || cur_cnt > 6) ? $urandom_range(1, 3) : cur_cnt;
    span  = (cur_len == 0 || cur_len > 8) ? 8 : cur_len;
    repeat (lines) begin
      repeat ($urandom_range(3)) begin
        if ($urandom_range(2) == 0) begin
          n = ($urandom_range(15) == 0) ? 32768 : $urandom_range(1, span);
          send_word(16'(32'h10000 - n));
        end else begin
          // one past the line end now and then
          n = $urandom_range(1, span + 1);
          send_word(16'(n));
          repeat (n) send_byte(8'($urandom));
        end
      end
      // stray byte knocks the command framing off
      if ($urandom_range(19) == 0) send_byte(8'($urandom));
      // line left unfinished, the next start recovers
      if ($urandom_range(11) == 0) return;
      send_word(16'h0000);
    end
  endtask

  initial begin
    #(RUN_LIMIT_NS);
    $display("simulation failed");
    $finish;
  end

  initial begin
    int unsigned seg;
    logic [15:0] len;
    logic [15:0] cnt;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    cur_comp = 1'b0;
    cur_len  = 1;
    cur_cnt  = 1;

    // fill the whole palette so no pixel ever reads an unwritten color
    for (int i = 0; i < PALETTE_DEPTH; i++) send_load(8'(i), $urandom_range(3) != 0);

    // reset format: a single pixel closes the image, then bytes are ignored
    send_byte(8'h00);
    send_byte(8'hA5);
    send_request(random_req(CMD_SPARE));
    send_start();
    send_byte(8'hFF);

    // zero line length in raw mode: every byte closes a line, all dropped
    set_format(1'b0, 1'b1, 16'd0, 16'd2);
    send_start();
    send_byte(8'h12);
    send_byte(8'hED);

    // widest image, skips that saturate the position, literal at the far end
    set_format(1'b1, 1'b1, 16'hFFFF, 16'hFFFF);
    send_start();
    send_word(16'hFFFF);
    send_word(16'h8000);
    send_word(16'h8000);
    send_word(16'h0001);
    send_byte(8'h3C);
    send_word(16'h0000);

    // literal run longer than the line, then the line ends the image
    set_format(1'b1, 1'b0, 16'd2, 16'd1);
    send_start();
    send_word(16'h0003);
    send_byte(8'h01);
    send_byte(8'h80);
    send_byte(8'h7E);
    send_word(16'h0000);

    // random formats and images under each idling pattern
    seg = 0;
    while (items_sent < ITEM_TARGET) begin
      len = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 16'hFFFF : 16'($urandom_range(1)))
                                     : 16'($urandom_range(1, 10));
      cnt = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 16'hFFFF : 16'($urandom_range(1)))
                                     : 16'($urandom_range(1, 5));
      set_format(1'($urandom_range(1)), 1'($urandom_range(1)), len, cnt);
      case (seg % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 50; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 50; end
        default: begin tx_idle_pct = 16; rx_stall_pct = 16; end
      endcase
      // long result-side hold while requests keep coming, to back up the block
      if (seg == 3) hold_asked++;
      repeat ($urandom_range(3, 6)) begin
        if (cur_comp) rle_image($urandom_range(7) != 0);
        else raw_image($urandom_range(7) != 0);
        if ($urandom_range(3) == 0) begin
          repeat ($urandom_range(1, 4)) send_load(8'($urandom), $urandom_range(3) != 0);
        end
        if ($urandom_range(15) == 0) send_request(random_req(CMD_SPARE));
        if ($urandom_range(9) == 0) drain_results();
      end
      seg++;
    end

    drain_results();
    repeat (16) @(posedge clk_i);
    if (check_errors == 0 && check_pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
